### rtl/edtk_pkg.sv
// shared types, operation codes and saturating cost arithmetic for the edit distance block
package edtk_pkg;

	localparam int DIST_W = 15;
	localparam int COST_W = 8;
	localparam int CFG_IDX_W = 3;

	typedef logic [DIST_W-1:0] dist_t;
	typedef logic [COST_W-1:0] cost_t;

	localparam dist_t DIST_MAX = {DIST_W{1'b1}};

	// item kinds
	localparam logic [1:0] KIND_SOURCE  = 2'd0;
	localparam logic [1:0] KIND_TARGET  = 2'd1;
	localparam logic [1:0] KIND_COMPUTE = 2'd2;

	// cost register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COPY    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DELETE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INSERT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TWIDDLE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_KILL    = 3'd5;

	// last operation of the optimal alignment
	typedef enum logic [2:0] {
		EDIT_COPY  = 3'd0,
		EDIT_SUBST = 3'd1,
		EDIT_DROP  = 3'd2,
		EDIT_ADD   = 3'd3,
		EDIT_SWAP  = 3'd4,
		EDIT_KILL  = 3'd5
	} op_t;

	// the six cost registers
	typedef struct packed {
		cost_t copy;
		cost_t repl;
		cost_t del;
		cost_t ins;
		cost_t twid;
		cost_t kill;
	} costs_t;

	// neighbors and qualifiers of one interior table cell
	typedef struct packed {
		dist_t diag;
		dist_t up;
		dist_t left;
		dist_t twoback;
		dist_t kmin;
		logic  match;
		logic  tw_en;
		logic  kill_en;
	} cell_in_t;

	typedef struct packed {
		dist_t val;
		op_t   op;
	} cell_out_t;

	// add a cost to a distance, clamped to the largest distance
	function automatic dist_t sat_add(dist_t a, cost_t b);
		logic [DIST_W:0] s;
		s = {1'b0, a} + {{(DIST_W + 1 - COST_W){1'b0}}, b};
		return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
	endfunction

endpackage

### rtl/edtk_cell.sv
// candidate evaluation and selection for one interior cell of the cost table
module edtk_cell (
	input  edtk_pkg::costs_t    cost,
	input  edtk_pkg::cell_in_t  ci,
	output edtk_pkg::cell_out_t co
);
	import edtk_pkg::*;

	// candidates in priority order, a later one wins only when strictly cheaper
	always_comb begin
		dist_t best;
		dist_t t;
		op_t   op;
		best = sat_add(ci.diag, ci.match ? cost.copy : cost.repl);
		op   = ci.match ? EDIT_COPY : EDIT_SUBST;
		t = sat_add(ci.up, cost.del);
		if (t < best) begin
			best = t;
			op   = EDIT_DROP;
		end
		t = sat_add(ci.left, cost.ins);
		if (t < best) begin
			best = t;
			op   = EDIT_ADD;
		end
		t = sat_add(ci.twoback, cost.twid);
		if (ci.tw_en && (t < best)) begin
			best = t;
			op   = EDIT_SWAP;
		end
		t = sat_add(ci.kmin, cost.kill);
		if (ci.kill_en && (t < best)) begin
			best = t;
			op   = EDIT_KILL;
		end
		co.val = best;
		co.op  = op;
	end

endmodule

### rtl/edit_distance_twiddle_kill.sv
// top level: symbol stores, column memory, row sweep sequencer and result register
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------------
//  in      | in_valid / in_stall    | kind, symbol
//  out     | out_valid / out_stall  | distance, final_op, length_overflow
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// a compute transaction sweeps the table one cell per cycle within a row through a column
// memory with one read and one write port: each of the m+1 rows reads columns 0 to n and
// then passes a drain state so the next row never reads an entry still being written, and
// the result is registered after the last row. reset clears counts, overflow flag and costs
// to their defaults; the stores and the column memory need no clearing. a compute transaction
// is held off while a result waits in the output register; loads are taken meanwhile.
module edit_distance_twiddle_kill #(
	parameter int MAX_LEN     = 64,
	parameter int SYMBOL_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          kind,
	input  logic [7:0]                          symbol,
	output logic                                out_valid,
	input  logic                                out_stall,
	output edtk_pkg::dist_t                     distance,
	output logic [2:0]                          final_op,
	output logic                                length_overflow,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [edtk_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [edtk_pkg::COST_W-1:0]         cfg_data
);
	import edtk_pkg::*;

	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_ISSUE = 4'b0010,
		S_DRAIN = 4'b0100,
		S_FIN   = 4'b1000
	} state_t;

	typedef logic [SYMBOL_BITS-1:0] sym_t;

	state_t state_q;
	costs_t cost_q;

	// symbol stores and column memory: entry j holds {c(i-1,j), c(i-2,j)}
	sym_t                  src_mem [MAX_LEN];
	sym_t                  tgt_mem [MAX_LEN];
	logic [2*DIST_W-1:0]   row_mem [MAX_LEN+1];
	sym_t                  src_rd_q;
	sym_t                  tgt_rd_q;
	logic [2*DIST_W-1:0]   row_rd_q;

	logic [CW-1:0] src_cnt_q;
	logic [CW-1:0] tgt_cnt_q;
	logic          drop_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] k_q;
	logic          proc_v_s1;
	logic [CW-1:0] proc_j_s1;

	dist_t bnd_q;
	dist_t kmin_q;
	dist_t diag_q;
	dist_t tb1_q;
	dist_t tb2_q;
	dist_t left_q;
	op_t   op_q;
	sym_t  a2_q;
	sym_t  tprev_q;

	logic  out_valid_q;
	dist_t dist_q;
	op_t   fop_q;
	logic  ovf_q;

	logic          in_acc;
	logic          start;
	logic          ld_src;
	logic          ld_tgt;
	sym_t          sym_in;
	logic          src_re;
	logic          tgt_re;
	logic [CW-1:0] i_m1;
	logic [CW-1:0] k_m1;
	dist_t         p1;
	dist_t         p2;
	logic          last_row;
	logic          last_col;
	cell_in_t      cell_in;
	cell_out_t     cell_out;
	dist_t         cell_val;
	logic          kmin_upd;

	// handshakes
	assign in_stall  = (state_q != S_IDLE) || (out_valid_q && (kind == KIND_COMPUTE));
	assign in_acc    = in_valid && !in_stall;
	assign start     = in_acc && (kind == KIND_COMPUTE);
	assign cfg_ready = 1'b1;

	assign sym_in = SYMBOL_BITS'(symbol);
	assign ld_src = in_acc && (kind == KIND_SOURCE) && (src_cnt_q < CW'(MAX_LEN));
	assign ld_tgt = in_acc && (kind == KIND_TARGET) && (tgt_cnt_q < CW'(MAX_LEN));

	// read addresses of the sweep
	assign i_m1   = i_q - CW'(1);
	assign k_m1   = k_q - CW'(1);
	assign src_re = (state_q == S_ISSUE) && (k_q == '0) && (i_q != '0);
	assign tgt_re = (state_q == S_ISSUE) && (k_q != '0);

	// symbol stores
	always_ff @(posedge clk) begin
		if (ld_src) begin
			src_mem[src_cnt_q[AW-1:0]] <= sym_in;
		end
		if (src_re) begin
			src_rd_q <= src_mem[i_m1[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (ld_tgt) begin
			tgt_mem[tgt_cnt_q[AW-1:0]] <= sym_in;
		end
		if (tgt_re) begin
			tgt_rd_q <= tgt_mem[k_m1[AW-1:0]];
		end
	end

	// column memory, read one column ahead of the cell being written
	always_ff @(posedge clk) begin
		if (proc_v_s1) begin
			row_mem[proc_j_s1] <= {cell_val, p1};
		end
		if (state_q == S_ISSUE) begin
			row_rd_q <= row_mem[k_q];
		end
	end

	// cell neighbors
	assign p1       = row_rd_q[2*DIST_W-1:DIST_W];
	assign p2       = row_rd_q[DIST_W-1:0];
	assign last_row = (i_q == src_cnt_q);
	assign last_col = (proc_j_s1 == tgt_cnt_q);

	always_comb begin
		cell_in.diag    = diag_q;
		cell_in.up      = p1;
		cell_in.left    = left_q;
		cell_in.twoback = tb2_q;
		cell_in.kmin    = kmin_q;
		cell_in.match   = (src_rd_q == tgt_rd_q);
		cell_in.tw_en   = (i_q > CW'(1)) && (proc_j_s1 > CW'(1)) &&
			(a2_q == tgt_rd_q) && (src_rd_q == tprev_q);
		cell_in.kill_en = last_row && last_col;
	end

	edtk_cell u_cell (
		.cost (cost_q),
		.ci   (cell_in),
		.co   (cell_out)
	);

	// boundary column and top row bypass the full cell
	always_comb begin
		if (proc_j_s1 == '0) begin
			cell_val = bnd_q;
		end else if (i_q == '0) begin
			cell_val = sat_add(left_q, cost_q.ins);
		end else begin
			cell_val = cell_out.val;
		end
	end

	assign kmin_upd = proc_v_s1 && last_col && !last_row && (cell_val < kmin_q);

	// sweep datapath
	always_ff @(posedge clk) begin
		if (proc_v_s1) begin
			diag_q  <= p1;
			tb1_q   <= p2;
			tb2_q   <= tb1_q;
			left_q  <= cell_val;
			op_q    <= cell_out.op;
			tprev_q <= tgt_rd_q;
		end
		if (src_re) begin
			a2_q <= src_rd_q;
		end
		if (start) begin
			kmin_q <= DIST_MAX;
		end else if (kmin_upd) begin
			kmin_q <= cell_val;
		end
		if (start) begin
			bnd_q <= '0;
		end else if ((state_q == S_DRAIN) && !last_row) begin
			bnd_q <= sat_add(bnd_q, cost_q.del);
		end
		if (state_q == S_ISSUE) begin
			proc_j_s1 <= k_q;
		end
	end

	// cost registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cost_q.copy <= 8'd0;
			cost_q.repl <= 8'd1;
			cost_q.del  <= 8'd2;
			cost_q.ins  <= 8'd3;
			cost_q.twid <= 8'd4;
			cost_q.kill <= 8'd5;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_COPY:    cost_q.copy <= cfg_data;
				REG_REPLACE: cost_q.repl <= cfg_data;
				REG_DELETE:  cost_q.del  <= cfg_data;
				REG_INSERT:  cost_q.ins  <= cfg_data;
				REG_TWIDDLE: cost_q.twid <= cfg_data;
				REG_KILL:    cost_q.kill <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer, string counts and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			src_cnt_q   <= '0;
			tgt_cnt_q   <= '0;
			drop_q      <= 1'b0;
			i_q         <= '0;
			k_q         <= '0;
			proc_v_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			proc_v_s1 <= (state_q == S_ISSUE);
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (ld_src) begin
						src_cnt_q <= src_cnt_q + CW'(1);
					end
					if (ld_tgt) begin
						tgt_cnt_q <= tgt_cnt_q + CW'(1);
					end
					if (in_acc && (kind inside {KIND_SOURCE, KIND_TARGET}) &&
						!ld_src && !ld_tgt) begin
						drop_q <= 1'b1;
					end
					if (start) begin
						i_q     <= '0;
						k_q     <= '0;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					if (k_q == tgt_cnt_q) begin
						state_q <= S_DRAIN;
					end else begin
						k_q <= k_q + CW'(1);
					end
				end
				S_DRAIN: begin
					if (last_row) begin
						state_q <= S_FIN;
					end else begin
						i_q     <= i_q + CW'(1);
						k_q     <= '0;
						state_q <= S_ISSUE;
					end
				end
				S_FIN: begin
					out_valid_q <= 1'b1;
					src_cnt_q   <= '0;
					tgt_cnt_q   <= '0;
					drop_q      <= 1'b0;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result payload, empty strings override the last operation
	always_ff @(posedge clk) begin
		if (state_q == S_FIN) begin
			dist_q <= left_q;
			ovf_q  <= drop_q;
			if (src_cnt_q == '0) begin
				fop_q <= EDIT_ADD;
			end else if (tgt_cnt_q == '0) begin
				fop_q <= EDIT_DROP;
			end else begin
				fop_q <= op_q;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign distance        = dist_q;
	assign final_op        = fop_q;
	assign length_overflow = ovf_q;

endmodule
